// ----- sv/sao_pkg.sv -----
package sao_pkg;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_BLEND = 1'b1;

  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_LEFT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOP    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd3;

  localparam int ENTRY_W = 32;

  typedef struct packed {
    logic        cmd;
    logic [11:0] sprite_index;
    logic [9:0]  pixel_col;
    logic [9:0]  pixel_row;
    logic [7:0]  chan_zero;
    logic [7:0]  chan_one;
    logic [7:0]  chan_two;
    logic [7:0]  alpha_in;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_zero;
    logic [7:0] out_one;
    logic [7:0] out_two;
    logic       covered;
  } out_word_t;

  // floor(x / 255), exact for x up to 255*255
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = 17'(x) + 17'd1 + 17'(x[15:8]);
    return t[15:8];
  endfunction

endpackage

// ----- sv/sao_ram.sv -----
module sao_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/sprite_alpha_overlay_top.sv -----
// Channel | Direction | Handshake             | Payload
// in_     | input     | in_valid / in_ready   | sao_pkg::in_word_t  (load or blend word)
// out_    | output    | out_valid / out_ready | sao_pkg::out_word_t (one per blend word)
// cfg_    | input     | cfg_we                | cfg_index, cfg_data
//
// One word accepted per cycle unless out_ready stalls the full stages.
// Stages: sprite store read, channel products and sum, divide by 255 into out reg.
// Each stage moves when the one after it is empty or moving, so bubbles collapse.
// Loads write the store on acceptance and give no result; a following blend reads
// the new value. rst_n clears control and config, not the data registers or the store.
module sprite_alpha_overlay_top #(
  parameter int SPRITE_SIDE = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  sao_pkg::in_word_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output sao_pkg::out_word_t            out_data,
  input  logic                          cfg_we,
  input  logic [sao_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sao_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sao_pkg::*;

  localparam int DEPTH  = SPRITE_SIDE * SPRITE_SIDE;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW     = (SPRITE_SIDE > 1) ? $clog2(SPRITE_SIDE) : 1;
  localparam logic [8:0]  SIDE_9  = 9'(SPRITE_SIDE);
  localparam logic [16:0] DEPTH_17 = 17'(DEPTH);

  // configuration
  logic [10:0] left_r, top_r;
  logic [6:0]  width_r, height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r   <= '0;
      top_r    <= '0;
      width_r  <= 7'd64;
      height_r <= 7'd64;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LEFT:   left_r   <= cfg_data;
        REG_TOP:    top_r    <= cfg_data;
        REG_WIDTH:  width_r  <= cfg_data[6:0];
        REG_HEIGHT: height_r <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // stage control
  logic s1_v_r, s2_v_r, out_valid_r;
  logic en1, en2, en_out, in_acc, blend_acc, load_acc;

  assign en_out   = !out_valid_r || out_ready;
  assign en2      = !s2_v_r || en_out;
  assign en1      = !s1_v_r || en2;
  assign in_ready = en1;
  assign in_acc   = in_valid && en1;
  assign blend_acc = in_acc && (in_data.cmd == CMD_BLEND);
  assign load_acc  = in_acc && (in_data.cmd == CMD_LOAD);

  // hit test and store address
  logic [8:0]         w_lim, h_lim;
  logic signed [11:0] fx, fy;
  logic               hit;
  logic [CW-1:0]      fx_idx, fy_idx;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic               ram_we, ram_re;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

  always_comb begin
    w_lim = ({2'b00, width_r}  > SIDE_9) ? SIDE_9 : {2'b00, width_r};
    h_lim = ({2'b00, height_r} > SIDE_9) ? SIDE_9 : {2'b00, height_r};
    fx = $signed({2'b00, in_data.pixel_col}) - $signed({left_r[10], left_r});
    fy = $signed({2'b00, in_data.pixel_row}) - $signed({top_r[10], top_r});
    hit = !fx[11] && (fx[10:0] < {2'b00, w_lim}) &&
          !fy[11] && (fy[10:0] < {2'b00, h_lim});
    fx_idx  = fx[CW-1:0];
    fy_idx  = fy[CW-1:0];
    rd_addr = AW'(AW'(fy_idx) * AW'(SPRITE_SIDE)) + AW'(fx_idx);
    wr_addr = AW'(in_data.sprite_index);
  end

  assign ram_we    = load_acc && (17'(in_data.sprite_index) < DEPTH_17);
  assign ram_re    = blend_acc;
  assign ram_wdata = {in_data.alpha_in, in_data.chan_two, in_data.chan_one,
                      in_data.chan_zero};

  sao_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_addr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // stage 1: store word arrives
  logic            s1_hit_r;
  logic [2:0][7:0] s1_bg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en1) begin
      s1_v_r <= blend_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_hit_r <= hit;
      s1_bg_r  <= {in_data.chan_two, in_data.chan_one, in_data.chan_zero};
    end
  end

  logic [7:0]       alpha;
  logic [2:0][7:0]  fg;
  logic [2:0][15:0] sum_nxt;

  always_comb begin
    alpha = s1_hit_r ? ram_rdata[31:24] : 8'd0;
    fg    = ram_rdata[23:0];
    for (int k = 0; k < 3; k++) begin
      sum_nxt[k] = 16'(16'(s1_bg_r[k]) * 16'(8'd255 - alpha)) +
                   16'(16'(fg[k]) * 16'(alpha));
    end
  end

  // stage 2: weighted sums
  logic [2:0][15:0] s2_sum_r;
  logic [2:0][7:0]  s2_bg_r;
  logic             s2_cov_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en2) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_sum_r <= sum_nxt;
      s2_bg_r  <= s1_bg_r;
      s2_cov_r <= (alpha != 8'd0);
    end
  end

  // output register
  out_word_t out_data_nxt, out_data_r;

  always_comb begin
    out_data_nxt.out_zero = s2_cov_r ? div255(s2_sum_r[0]) : s2_bg_r[0];
    out_data_nxt.out_one  = s2_cov_r ? div255(s2_sum_r[1]) : s2_bg_r[1];
    out_data_nxt.out_two  = s2_cov_r ? div255(s2_sum_r[2]) : s2_bg_r[2];
    out_data_nxt.covered  = s2_cov_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en_out) begin
      out_valid_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_load_no_result : assert property (@(posedge clk) disable iff (!rst_n)
    load_acc |=> !s1_v_r)
    else $error("load word entered the result pipe");

  a_blend_enters : assert property (@(posedge clk) disable iff (!rst_n)
    blend_acc |=> s1_v_r)
    else $error("accepted blend word lost at store read");

  a_no_drop : assert property (@(posedge clk) disable iff (!rst_n)
    (s2_v_r && out_valid_r && !out_ready) |=> (s2_v_r && out_valid_r))
    else $error("stalled word dropped");

  a_store_port : assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("store read and write in one cycle");

endmodule
